@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the blink timer RTL. They expect clk and rst
// in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/mlbt_pkg.sv @@
// ----------------------------------------------------------------------------
// mlbt_pkg
// Shared constants and types of the multi-LED blink timer.
// ----------------------------------------------------------------------------
package mlbt_pkg;

  localparam int NUM_LEDS_DEF = 4;

  // Field widths
  localparam int OP_W    = 3;
  localparam int TIME_W  = 16;
  localparam int CYC_W   = TIME_W + 1;
  localparam int STEP_W  = $clog2(TIME_W);
  localparam int MASK_W  = 4;

  // Command codes
  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_ON    = 3'd3;
  localparam logic [OP_W-1:0] OP_OFF   = 3'd4;

  // Request to the serial remainder unit
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [CYC_W-1:0]  divisor;
  } mod_req_t;

  // Response from the serial remainder unit
  typedef struct packed {
    logic             done;
    logic [CYC_W-1:0] rem;
  } mod_rsp_t;

endpackage

@@ rtl/multi_led_blink_timer.sv @@
// Sequence: direct commands (start, stop, on, off, unused codes) go from S_IDLE
//   to S_EMIT; a tick visits S_SCAN for every LED and S_MOD for each counting
//   LED with a non-zero cycle length, then S_EMIT, which waits for the output.
// Throughput: one item at a time; the 16-step serial remainder unit takes up most
//   of a tick. The next item is taken while a result waits at the output.
// Reset: synchronous, active high; all LEDs dark, counts cleared, tick off.
// ----------------------------------------------------------------------------
// multi_led_blink_timer
// Four-channel LED blink controller. A tick walks the LEDs one by one and
// runs count modulo cycle length through a shared serial remainder unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_led_blink_timer #(
  parameter int NUM_LEDS = mlbt_pkg::NUM_LEDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Command channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mlbt_pkg::OP_W-1:0]   op,
  input  logic [1:0]                  led_index,
  input  logic [mlbt_pkg::TIME_W-1:0] on_time,
  input  logic [mlbt_pkg::TIME_W-1:0] off_time,
  input  logic [mlbt_pkg::TIME_W-1:0] duration,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mlbt_pkg::MASK_W-1:0] lit_mask,
  output logic                        tick_enabled
);

  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,   // wait for an item
    S_SCAN,   // look at LED k, start the remainder unit if it is counting with a non-zero cycle length
    S_MOD,    // wait for the remainder, then update LED k
    S_EMIT    // place the result in the output register
  } state_t;

  state_t state;

  // Per-LED blink state; read at the scan pointer, remaining also in full
  logic [mlbt_pkg::CYC_W-1:0]  cycle_length [NUM_LEDS];
  logic [mlbt_pkg::TIME_W-1:0] dark_point   [NUM_LEDS];
  logic [mlbt_pkg::TIME_W-1:0] remaining    [NUM_LEDS];
  logic [NUM_LEDS-1:0]         lit;
  logic                        ticking;

  // Tick sweep
  logic [IDX_W-1:0]            k;
  logic                        all_idle;

  // Remainder unit
  mlbt_pkg::mod_req_t          mod_req;
  mlbt_pkg::mod_rsp_t          mod_rsp;

  // Decoded values
  logic [IDX_W-1:0]            cmd_idx;
  logic                        idx_ok;
  logic [mlbt_pkg::TIME_W-1:0] cur_rem;
  logic [mlbt_pkg::CYC_W-1:0]  cur_cyc;
  logic                        cur_counting;
  logic                        cur_last_tick;
  logic                        last_led;
  logic [NUM_LEDS+3:0]         lit_ext;
  logic [NUM_LEDS-1:0]         counting_vec;
  logic                        any_counting;

  // Hold the command index at the array's index width; drop out-of-range LEDs
  assign cmd_idx = IDX_W'(led_index);
  assign idx_ok  = (6'(led_index) < 6'(NUM_LEDS));

  assign cur_rem       = remaining[k];
  assign cur_cyc       = cycle_length[k];
  assign cur_counting  = (cur_rem > mlbt_pkg::TIME_W'(1));
  assign cur_last_tick = (cur_rem == mlbt_pkg::TIME_W'(1));
  assign last_led      = (k == IDX_W'(NUM_LEDS - 1));

  // Only LEDs 0..3 are reported
  assign lit_ext = {4'b0000, lit};

  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      counting_vec[i] = (remaining[i] != '0);
    end
  end
  assign any_counting = |counting_vec;

  // Start the remainder for a counting LED with a non-zero cycle length
  assign mod_req.start    = (state == S_SCAN) && cur_counting && (cur_cyc != '0);
  assign mod_req.dividend = cur_rem;
  assign mod_req.divisor  = cur_cyc;

  mlbt_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ticking   <= 1'b0;
      lit       <= '0;
      k         <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        remaining[i] <= '0;
      end
    end else begin
      // Drop the result once the consumer has taken it; in S_EMIT the next
      // result takes its place instead
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (op == mlbt_pkg::OP_TICK) begin
              k        <= '0;
              all_idle <= 1'b1;
              state    <= S_SCAN;
            end else begin
              if (idx_ok) begin
                case (op)
                  mlbt_pkg::OP_START: begin
                    dark_point[cmd_idx]   <= off_time;
                    cycle_length[cmd_idx] <= {1'b0, on_time} + {1'b0, off_time};
                    remaining[cmd_idx]    <= duration;
                    ticking               <= 1'b1;
                    lit[cmd_idx]          <= 1'b1;
                  end
                  mlbt_pkg::OP_STOP: begin
                    remaining[cmd_idx] <= '0;
                    lit[cmd_idx]       <= 1'b0;
                  end
                  mlbt_pkg::OP_ON: begin
                    lit[cmd_idx] <= 1'b1;
                  end
                  mlbt_pkg::OP_OFF: begin
                    lit[cmd_idx] <= 1'b0;
                  end
                  default: begin
                    // unused codes leave the state alone
                  end
                endcase
              end
              state <= S_EMIT;
            end
          end
        end

        S_SCAN: begin
          if (cur_counting) begin
            all_idle <= 1'b0;
            if (cur_cyc != '0) begin
              state <= S_MOD;
            end else begin
              // Zero period: hold the level, just count down
              remaining[k] <= cur_rem - mlbt_pkg::TIME_W'(1);
              if (last_led) begin
                state <= S_EMIT;
              end else begin
                k <= k + IDX_W'(1);
              end
            end
          end else begin
            // Final tick of a blink darkens the LED and ends it
            if (cur_last_tick) begin
              lit[k]       <= 1'b0;
              remaining[k] <= '0;
            end
            if (last_led) begin
              if (all_idle) begin
                ticking <= 1'b0;
              end
              state <= S_EMIT;
            end else begin
              k <= k + IDX_W'(1);
            end
          end
        end

        S_MOD: begin
          if (mod_rsp.done) begin
            // Phase zero lights the LED, phase at the dark point darkens it
            if (mod_rsp.rem == '0) begin
              lit[k] <= 1'b1;
            end else if (mod_rsp.rem == {1'b0, dark_point[k]}) begin
              lit[k] <= 1'b0;
            end
            remaining[k] <= cur_rem - mlbt_pkg::TIME_W'(1);
            if (last_led) begin
              state <= S_EMIT;
            end else begin
              k     <= k + IDX_W'(1);
              state <= S_SCAN;
            end
          end
        end

        S_EMIT: begin
          // Wait until the output register is free or being emptied
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            lit_mask     <= lit_ext[mlbt_pkg::MASK_W-1:0];
            tick_enabled <= ticking;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // After an accepted item the block is always busy in the following cycle
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // The remainder unit only reports while the sequencer is waiting on it
  `ASSERT_SAME(a_done_in_wait, mod_rsp.done, state == S_MOD)
  // With the tick source off no LED may still hold a count
  `ASSERT_SAME(a_idle_when_off, !ticking, !any_counting)

endmodule

@@ rtl/mlbt_mod.sv @@
// ----------------------------------------------------------------------------
// mlbt_mod
// Serial restoring remainder unit: one dividend bit a cycle, done pulse
// after the last bit.
// ----------------------------------------------------------------------------
module mlbt_mod (
  input  logic              clk,
  input  logic              rst,
  input  mlbt_pkg::mod_req_t req,
  output mlbt_pkg::mod_rsp_t rsp
);

  typedef enum logic {
    M_IDLE,
    M_RUN
  } mod_state_t;

  mod_state_t                      state;
  logic [mlbt_pkg::TIME_W-1:0]     shift;
  logic [mlbt_pkg::CYC_W-1:0]      divisor;
  logic [mlbt_pkg::CYC_W-1:0]      rem;
  logic [mlbt_pkg::STEP_W-1:0]     step;
  logic                            done;

  logic [mlbt_pkg::CYC_W:0]        trial;
  logic [mlbt_pkg::CYC_W+1:0]      diff;

  // Shift in the next dividend bit, subtract when it fits
  assign trial = {rem, shift[mlbt_pkg::TIME_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        M_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            shift   <= req.dividend;
            divisor <= req.divisor;
            rem     <= '0;
            step    <= '0;
            state   <= M_RUN;
          end
        end
        M_RUN: begin
          if (diff[mlbt_pkg::CYC_W+1]) begin
            rem <= trial[mlbt_pkg::CYC_W-1:0];
          end else begin
            rem <= diff[mlbt_pkg::CYC_W-1:0];
          end
          shift <= {shift[mlbt_pkg::TIME_W-2:0], 1'b0};
          step  <= step + mlbt_pkg::STEP_W'(1);
          if (step == mlbt_pkg::STEP_W'(mlbt_pkg::TIME_W - 1)) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

@@ tb/multi_led_blink_timer_test.sv @@
// ----------------------------------------------------------------------------
// multi_led_blink_timer_test
// Self-checking bench for the four-channel LED blink controller. Command items
// go in over a valid/ready channel with random gaps. A predictor written
// here works out the lit mask and tick enable that each item should give.
// A checker compares each result item with the oldest prediction while the
// result channel stalls at random.
// ----------------------------------------------------------------------------
module multi_led_blink_timer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_LEDS = mlbt_pkg::NUM_LEDS_DEF;
  // Codes above the last command are left unused by the block
  localparam logic [mlbt_pkg::OP_W-1:0] OP_FIRST_UNUSED = mlbt_pkg::OP_OFF + 1'b1;
  localparam logic [mlbt_pkg::OP_W-1:0] OP_TOP          = {mlbt_pkg::OP_W{1'b1}};
  // Latency of the slowest item (a tick with every LED counting), with margin
  localparam int DRAIN_CYCLES = 2 + 18 * N_LEDS + 16;
  localparam int BLINK_ITEMS  = 580;
  localparam int TOTAL_ITEMS  = 720;

  typedef struct packed {
    logic [mlbt_pkg::MASK_W-1:0] lit_mask;
    logic                        tick_enabled;
  } blink_result_t;

  // Clock, reset and ports; every input holds a known value from time zero
  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [mlbt_pkg::OP_W-1:0]   op = mlbt_pkg::OP_TICK;
  logic [1:0]                  led_index = '0;
  logic [mlbt_pkg::TIME_W-1:0] on_time = '0;
  logic [mlbt_pkg::TIME_W-1:0] off_time = '0;
  logic [mlbt_pkg::TIME_W-1:0] duration = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [mlbt_pkg::MASK_W-1:0] lit_mask;
  logic                        tick_enabled;

  // Predicted blink state, one entry per LED
  logic [mlbt_pkg::CYC_W-1:0]  cycle_len [N_LEDS];
  logic [mlbt_pkg::TIME_W-1:0] dark_at [N_LEDS];
  logic [mlbt_pkg::TIME_W-1:0] ticks_left [N_LEDS];
  logic                        led_lit [N_LEDS];
  logic                        tick_on;

  blink_result_t pending_results[$];
  int            mismatches = 0;
  int            items_sent = 0;
  int            stall_left = 0;
  // Set to run a stretch with neither side pausing
  bit            steady_flow = 1'b0;

  multi_led_blink_timer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .led_index    (led_index),
    .on_time      (on_time),
    .off_time     (off_time),
    .duration     (duration),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .lit_mask     (lit_mask),
    .tick_enabled (tick_enabled)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Give up after a fixed time, several times the slowest correct run
  initial begin
    #12ms;
    $display("Mismatches found");
    $finish;
  end

  // Clear the predicted state to its reset values
  task automatic clear_blink_state();
    for (int k = 0; k < N_LEDS; k++) begin
      cycle_len[k]  = '0;
      dark_at[k]    = '0;
      ticks_left[k] = '0;
      led_lit[k]    = 1'b0;
    end
    tick_on = 1'b0;
  endtask

  // Advance every LED by one tick: relight at a whole cycle, darken at the
  // dark point, count down, and darken for good on the last count
  function automatic void advance_blinks();
    int          idle_leds;
    int unsigned phase;
    idle_leds = 0;
    for (int k = 0; k < N_LEDS; k++) begin
      if (ticks_left[k] > 1) begin
        // A zero cycle length keeps the level as it is
        if (cycle_len[k] != 0) begin
          phase = int'(ticks_left[k]) % int'(cycle_len[k]);
          if (phase == 0) begin
            led_lit[k] = 1'b1;
          end else if (phase == int'(dark_at[k])) begin
            led_lit[k] = 1'b0;
          end
        end
        ticks_left[k] = ticks_left[k] - 1'b1;
      end else if (ticks_left[k] == 1) begin
        led_lit[k]    = 1'b0;
        ticks_left[k] = '0;
        idle_leds++;
      end else begin
        idle_leds++;
      end
    end
    if (idle_leds == N_LEDS) tick_on = 1'b0;
  endfunction

  // Apply one accepted command item and return the lit mask and enable
  function automatic blink_result_t predict_blink_result(
    logic [mlbt_pkg::OP_W-1:0] cmd, logic [1:0] idx,
    logic [mlbt_pkg::TIME_W-1:0] on_v, logic [mlbt_pkg::TIME_W-1:0] off_v,
    logic [mlbt_pkg::TIME_W-1:0] dur_v
  );
    blink_result_t res;
    if (cmd == mlbt_pkg::OP_TICK) begin
      advance_blinks();
    end else if (int'(idx) < N_LEDS) begin
      case (cmd)
        mlbt_pkg::OP_START: begin
          dark_at[idx]    = off_v;
          cycle_len[idx]  = {1'b0, on_v} + {1'b0, off_v};
          ticks_left[idx] = dur_v;
          tick_on         = 1'b1;
          led_lit[idx]    = 1'b1;
        end
        mlbt_pkg::OP_STOP: begin
          ticks_left[idx] = '0;
          led_lit[idx]    = 1'b0;
        end
        mlbt_pkg::OP_ON:  led_lit[idx] = 1'b1;
        mlbt_pkg::OP_OFF: led_lit[idx] = 1'b0;
        default: ;  // unused codes leave everything as it is
      endcase
    end
    res.lit_mask = '0;
    for (int k = 0; k < N_LEDS && k < mlbt_pkg::MASK_W; k++) begin
      res.lit_mask[k] = led_lit[k];
    end
    res.tick_enabled = tick_on;
    return res;
  endfunction

  // Pick a pause length: mostly none, some short, a few long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Send one command item. Drop valid only when a gap follows, so that valid
  // sees a single assignment per edge; hold it until the item is taken, then
  // record the prediction for it.
  task automatic send_command(
    logic [mlbt_pkg::OP_W-1:0] cmd, logic [1:0] idx,
    logic [mlbt_pkg::TIME_W-1:0] on_v, logic [mlbt_pkg::TIME_W-1:0] off_v,
    logic [mlbt_pkg::TIME_W-1:0] dur_v
  );
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= cmd;
    led_index <= idx;
    on_time   <= on_v;
    off_time  <= off_v;
    duration  <= dur_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_blink_result(cmd, idx, on_v, off_v, dur_v));
    items_sent++;
  endtask

  // A tick whose unused fields carry random values
  task automatic send_tick();
    send_command(mlbt_pkg::OP_TICK, 2'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
  endtask

  // Compare one result item with the oldest prediction, field by field
  task automatic check_result();
    blink_result_t want;
    if (pending_results.size() == 0) begin
      $error("result item with no prediction waiting: lit_mask %h, tick_enabled %b",
             lit_mask, tick_enabled);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (lit_mask !== want.lit_mask) begin
        $error("lit_mask: expected %h, got %h", want.lit_mask, lit_mask);
        mismatches++;
      end
      if (tick_enabled !== want.tick_enabled) begin
        $error("tick_enabled: expected %b, got %b", want.tick_enabled, tick_enabled);
        mismatches++;
      end
    end
  endtask

  // Result side: check on each taken item, then stall ready at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    if (stall_left == 0 && !steady_flow && $urandom_range(0, 3) == 0) begin
      stall_left = pick_pause();
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Tick with nothing blinking, then the unused command codes
  task automatic test_idle_and_unused();
    send_tick();
    for (logic [mlbt_pkg::OP_W-1:0] c = OP_FIRST_UNUSED;
         c <= OP_TOP && c >= OP_FIRST_UNUSED; c++) begin
      send_command(c, 2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Blink starts at the field extremes: zero cycle, widest cycle, one tick,
  // zero duration; then a few ticks over them
  task automatic test_blink_extremes();
    send_command(mlbt_pkg::OP_START, 2'd0, 16'h0000, 16'h0000, 16'hFFFF);
    send_command(mlbt_pkg::OP_START, 2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(mlbt_pkg::OP_START, 2'd2, 16'h0001, 16'h0001, 16'h0001);
    send_command(mlbt_pkg::OP_START, 2'd3, 16'h0002, 16'h0001, 16'h0000);
    repeat (3) send_tick();
  endtask

  // Direct on and off, during a blink too, then stops until the enable drops
  task automatic test_direct_commands();
    send_command(mlbt_pkg::OP_ON,  2'd3, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_command(mlbt_pkg::OP_OFF, 2'd1, 16'h0000, 16'hFFFF, 16'h0000);
    send_command(mlbt_pkg::OP_ON,  2'd1, 16'h5A5A, 16'hA5A5, 16'h0F0F);
    send_tick();
    send_command(mlbt_pkg::OP_STOP, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    send_command(mlbt_pkg::OP_STOP, 2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(mlbt_pkg::OP_OFF,  2'd3, 16'h1234, 16'h4321, 16'h0000);
    repeat (2) send_tick();
  endtask

  // Well-formed blink sessions: a few starts, mostly with short cycles, then a run
  // of ticks with the odd direct command or stop mixed in
  task automatic test_blink_sessions();
    int n_starts;
    int n_ticks;
    int r;
    while (items_sent < BLINK_ITEMS) begin
      steady_flow = ($urandom_range(0, 7) == 0);
      n_starts = $urandom_range(1, 3);
      repeat (n_starts) begin
        if ($urandom_range(0, 9) == 0) begin
          send_command(mlbt_pkg::OP_START, 2'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
        end else begin
          send_command(mlbt_pkg::OP_START, 2'($urandom), 16'($urandom_range(0, 6)),
                       16'($urandom_range(0, 6)), 16'($urandom_range(0, 30)));
        end
      end
      n_ticks = $urandom_range(4, 40);
      repeat (n_ticks) begin
        r = $urandom_range(0, 19);
        case (r)
          0:       send_command(mlbt_pkg::OP_STOP, 2'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
          1:       send_command(mlbt_pkg::OP_ON, 2'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
          2:       send_command(mlbt_pkg::OP_OFF, 2'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
          default: send_tick();
        endcase
      end
    end
    steady_flow = 1'b0;
  endtask

  // Noise: any code, any field values
  task automatic test_random_noise();
    while (items_sent < TOTAL_ITEMS) begin
      send_command(mlbt_pkg::OP_W'($urandom), 2'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    clear_blink_state();
    // Hold reset from time zero, then release it
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_idle_and_unused();
    test_blink_extremes();
    test_direct_commands();
    test_blink_sessions();
    test_random_noise();

    // Drop valid on the last acceptance edge and drain the results
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
